/* sv/rational_multiply_divide_reduce_unit_defines.svh */
// ---------------------------------------------------------------------------
// Rational multiply / divide / reduce unit: assertion macros
// Shared check macros, sampled on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef RATIONAL_MULTIPLY_DIVIDE_REDUCE_UNIT_DEFINES_SVH
`define RATIONAL_MULTIPLY_DIVIDE_REDUCE_UNIT_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define RMDR_CHECK_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmdr same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent
`define RMDR_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmdr next-cycle check failed");

`endif

/* sv/rmdr_pkg.sv */
// ---------------------------------------------------------------------------
// rmdr_pkg
// Types, codes and helpers shared by the rational multiply / divide /
// reduce unit, its controller and its datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package rmdr_pkg;

  // Operand, product and result widths
  localparam int OPW = 16;
  localparam int PW  = 2 * OPW;
  localparam int RW  = 32;
  localparam int CW  = $clog2(PW + 1);

  // Command codes
  localparam logic [1:0] CMD_REDUCE   = 2'd0;
  localparam logic [1:0] CMD_MULTIPLY = 2'd1;
  localparam logic [1:0] CMD_DIVIDE   = 2'd2;
  localparam logic [1:0] CMD_COMPARE  = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_ZERO_DEN = 2'd1;
  localparam logic [1:0] ERR_DIV_ZERO = 2'd2;

  typedef struct packed {
    logic [1:0]            command;
    logic signed [OPW-1:0] left_numerator;
    logic signed [OPW-1:0] left_denominator;
    logic signed [OPW-1:0] right_numerator;
    logic signed [OPW-1:0] right_denominator;
  } in_item_t;

  typedef struct packed {
    logic signed [RW-1:0] result_numerator;
    logic signed [RW-1:0] result_denominator;
    logic                 is_equal;
    logic                 is_one;
    logic [1:0]           error_code;
  } out_item_t;

  // Controller states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_GCD  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic short_path;
    logic gcd_done;
  } dp_sts_t;

  // Magnitude of a signed operand as an unsigned value of the same width
  function automatic logic [OPW-1:0] mag_op(input logic signed [OPW-1:0] v);
    logic signed [OPW-1:0] neg;
    neg = -v;
    return v[OPW-1] ? OPW'(neg) : OPW'(v);
  endfunction

endpackage

`default_nettype wire

/* sv/rmdr_datapath.sv */
// ---------------------------------------------------------------------------
// rmdr_datapath
// Operand register, magnitude multipliers, binary gcd, a two-lane
// restoring divider sharing the gcd as divisor, and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module rmdr_datapath (
  input  logic                 clk,
  input  rmdr_pkg::in_item_t   in_data,
  input  rmdr_pkg::dp_cmd_t    cmd,
  output rmdr_pkg::dp_sts_t    sts,
  output rmdr_pkg::out_item_t  out_data
);
  import rmdr_pkg::*;

  in_item_t        op_r;
  logic [PW-1:0]   nm_r, dm_r;        // product magnitudes
  logic            num_neg_r, den_neg_r;
  logic [PW-1:0]   ga_r, gb_r;        // gcd working pair, gb ends as the gcd
  logic [CW-1:0]   k_r;               // common factors of two
  logic [PW-1:0]   rn_r, qn_r;        // numerator lane remainder and quotient
  logic [PW-1:0]   rd_r, qd_r;        // denominator lane remainder and quotient
  out_item_t       out_r;

  // Operand magnitudes and signs
  logic [OPW-1:0]  ln_m, ld_m, rn_m, rd_m, mul_a, mul_b;
  logic            sgn_a, sgn_b;
  logic [PW-1:0]   prod_n, prod_d;
  logic [1:0]      err_c;
  logic            eq_c;

  assign ln_m = mag_op(op_r.left_numerator);
  assign ld_m = mag_op(op_r.left_denominator);
  assign rn_m = mag_op(op_r.right_numerator);
  assign rd_m = mag_op(op_r.right_denominator);

  // Select the right-hand factors by command
  always_comb begin
    case (op_r.command)
      CMD_REDUCE: begin
        mul_a = OPW'(1);
        mul_b = OPW'(1);
        sgn_a = 1'b0;
        sgn_b = 1'b0;
      end
      CMD_DIVIDE: begin
        mul_a = rd_m;
        mul_b = rn_m;
        sgn_a = op_r.right_denominator[OPW-1];
        sgn_b = op_r.right_numerator[OPW-1];
      end
      default: begin
        mul_a = rn_m;
        mul_b = rd_m;
        sgn_a = op_r.right_numerator[OPW-1];
        sgn_b = op_r.right_denominator[OPW-1];
      end
    endcase
  end

  assign prod_n = {{OPW{1'b0}}, ln_m} * {{OPW{1'b0}}, mul_a};
  assign prod_d = {{OPW{1'b0}}, ld_m} * {{OPW{1'b0}}, mul_b};

  // Error detection, denominator check before divisor check
  always_comb begin
    err_c = ERR_NONE;
    if (op_r.command != CMD_COMPARE) begin
      if (op_r.left_denominator == '0 ||
          (op_r.command != CMD_REDUCE && op_r.right_denominator == '0)) begin
        err_c = ERR_ZERO_DEN;
      end else if (op_r.command == CMD_DIVIDE && op_r.right_numerator == '0) begin
        err_c = ERR_DIV_ZERO;
      end
    end
  end

  assign eq_c = (op_r.left_numerator == op_r.right_numerator) &&
                (op_r.left_denominator == op_r.right_denominator);

  assign sts.short_path = (op_r.command == CMD_COMPARE) || (err_c != ERR_NONE);
  assign sts.gcd_done   = (ga_r == '0) && (k_r == '0);

  // Binary gcd step terms
  logic [PW-1:0] ab_diff, ba_diff;
  assign ab_diff = ga_r - gb_r;
  assign ba_diff = gb_r - ga_r;

  // Divider step terms
  logic [PW:0] n_sh, d_sh, n_diff, d_diff;
  assign n_sh   = {rn_r, qn_r[PW-1]};
  assign d_sh   = {rd_r, qd_r[PW-1]};
  assign n_diff = n_sh - {1'b0, gb_r};
  assign d_diff = d_sh - {1'b0, gb_r};

  // Hold operands on accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_data;
    end
  end

  // Form products and seed the gcd
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      nm_r      <= prod_n;
      dm_r      <= prod_d;
      ga_r      <= prod_n;
      gb_r      <= prod_d;
      k_r       <= '0;
      num_neg_r <= op_r.left_numerator[OPW-1] ^ sgn_a;
      den_neg_r <= op_r.left_denominator[OPW-1] ^ sgn_b;
    end else if (cmd.gcd_step) begin
      if (ga_r == '0) begin
        gb_r <= {gb_r[PW-2:0], 1'b0};
        k_r  <= k_r - CW'(1);
      end else if (!ga_r[0] && !gb_r[0]) begin
        ga_r <= ga_r >> 1;
        gb_r <= gb_r >> 1;
        k_r  <= k_r + CW'(1);
      end else if (!ga_r[0]) begin
        ga_r <= ga_r >> 1;
      end else if (!gb_r[0]) begin
        gb_r <= gb_r >> 1;
      end else if (ga_r >= gb_r) begin
        ga_r <= ab_diff >> 1;
      end else begin
        gb_r <= ba_diff >> 1;
      end
    end
  end

  // Divide both magnitudes by the gcd, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rn_r <= '0;
      rd_r <= '0;
      qn_r <= nm_r;
      qd_r <= dm_r;
    end else if (cmd.div_step) begin
      rn_r <= n_diff[PW] ? n_sh[PW-1:0] : n_diff[PW-1:0];
      rd_r <= d_diff[PW] ? d_sh[PW-1:0] : d_diff[PW-1:0];
      qn_r <= {qn_r[PW-2:0], ~n_diff[PW]};
      qd_r <= {qd_r[PW-2:0], ~d_diff[PW]};
    end
  end

  // Apply signs and wrap to the result width
  logic [PW-1:0]        qn_neg, qd_neg;
  logic signed [PW-1:0] sn, sd;
  out_item_t            res_c;

  assign qn_neg = -qn_r;
  assign qd_neg = -qd_r;
  assign sn     = num_neg_r ? qn_neg : qn_r;
  assign sd     = den_neg_r ? qd_neg : qd_r;

  always_comb begin
    res_c = '0;
    if (op_r.command == CMD_COMPARE) begin
      res_c.is_equal = eq_c;
    end else if (err_c != ERR_NONE) begin
      res_c.error_code = err_c;
    end else begin
      res_c.result_numerator   = RW'(sn);
      res_c.result_denominator = RW'(sd);
      res_c.is_one = !num_neg_r && !den_neg_r &&
                     (qn_r == PW'(1)) && (qd_r == PW'(1));
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= res_c;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

/* sv/rmdr_ctrl.sv */
// ---------------------------------------------------------------------------
// rmdr_ctrl
// Sequencer, one transaction at a time: multiply, gcd and divide loops
// (skipped on the short path), then load the output register when free.
// ---------------------------------------------------------------------------
`default_nettype none

module rmdr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  rmdr_pkg::dp_sts_t  sts,
  output rmdr_pkg::dp_cmd_t  cmd
);
  import rmdr_pkg::*;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = sts.short_path ? ST_DONE : ST_GCD;
      end
      ST_GCD: begin
        if (sts.gcd_done) begin
          cmd.div_init = 1'b1;
          cnt_nxt      = CW'(PW - 1);
          state_nxt    = ST_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Track the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/rational_multiply_divide_reduce_unit.sv */
// ---------------------------------------------------------------------------
// rational_multiply_divide_reduce_unit
// Reduce, multiply, divide or compare signed fractions, with gcd reduction.
// ---------------------------------------------------------------------------
// One transaction is worked on at a time. Compare and error transactions
// skip the gcd and divide loops. Reduce, multiply and divide run the binary
// gcd loop on the PW-bit products, where PW is twice the operand width: the
// gcd takes one subtract-or-shift step per cycle, and the shared restoring
// divider then produces one quotient bit per cycle for numerator and
// denominator together. A finished result waits in the output register
// while the next transaction is accepted. Denominator signs are kept as
// computed.
`default_nettype none
`include "rational_multiply_divide_reduce_unit_defines.svh"

module rational_multiply_divide_reduce_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rmdr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rmdr_pkg::out_item_t out_data
);
  import rmdr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rmdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rmdr_datapath u_datapath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // Checks
  `RMDR_CHECK_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `RMDR_CHECK_SAME(a_error_clears_fields, out_valid && (out_data.error_code != ERR_NONE), (out_data.result_numerator == '0) && (out_data.result_denominator == '0) && !out_data.is_one && !out_data.is_equal)
  `RMDR_CHECK_SAME(a_equal_only_compare, out_valid && out_data.is_equal, (out_data.result_numerator == '0) && (out_data.result_denominator == '0) && (out_data.error_code == ERR_NONE))
  `RMDR_CHECK_SAME(a_one_is_one_over_one, out_valid && out_data.is_one, (out_data.result_numerator == 32'sd1) && (out_data.result_denominator == 32'sd1))

endmodule

`default_nettype wire
